// ===== src/b64u_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package b64u_pkg;

    localparam int unsigned SymW   = 8;
    localparam int unsigned QDepth = 2;

    // One 24-bit group waiting to be serialized. last_idx is the index of the
    // final character of the group (1, 2 or 3).
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  last_idx;
        logic        final_grp;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // base64url alphabet lookup
    function automatic logic [SymW-1:0] sextet_char(input logic [5:0] idx);
        logic [SymW-1:0] wide;
        wide = SymW'(idx);
        if (idx < 6'd26) begin
            sextet_char = wide + 8'h41;
        end else if (idx < 6'd52) begin
            sextet_char = wide + 8'h47;
        end else if (idx < 6'd62) begin
            sextet_char = wide - 8'h04;
        end else if (idx == 6'd62) begin
            sextet_char = 8'h2d;
        end else begin
            sextet_char = 8'h5f;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/b64u_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64u_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [7:0]       i_s_tdata,
    input  wire logic             i_s_tlast,
    input  wire b64u_pkg::t_q_stat i_q_stat,
    output logic                  o_push,
    output b64u_pkg::t_group      o_grp
);
    import b64u_pkg::*;

    logic [15:0] r_pend;
    logic [1:0]  r_cnt;
    logic [15:0] n_pend;
    logic [1:0]  n_cnt;
    logic        accept;

    assign o_s_tready = !i_q_stat.full;
    assign accept     = i_s_tvalid && !i_q_stat.full;
    assign o_push     = accept && (i_s_tlast || r_cnt[1]);

    always_comb begin
        case (r_cnt)
            2'd0: begin
                o_grp.bits      = {i_s_tdata, 16'h0000};
                o_grp.last_idx  = 2'd1;
                o_grp.final_grp = 1'b1;
            end
            2'd1: begin
                o_grp.bits      = {r_pend[15:8], i_s_tdata, 8'h00};
                o_grp.last_idx  = 2'd2;
                o_grp.final_grp = 1'b1;
            end
            default: begin
                // a count of three is handled like two
                o_grp.bits      = {r_pend, i_s_tdata};
                o_grp.last_idx  = 2'd3;
                o_grp.final_grp = i_s_tlast;
            end
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (accept) begin
            if (o_push) begin
                n_pend = 16'h0000;
                n_cnt  = 2'd0;
            end else if (r_cnt == 2'd0) begin
                n_pend = {i_s_tdata, 8'h00};
                n_cnt  = 2'd1;
            end else begin
                n_pend = {r_pend[15:8], i_s_tdata};
                n_cnt  = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'h0000;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== src/b64u_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64u_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire b64u_pkg::t_group  i_grp,
    input  wire logic              i_pop,
    output b64u_pkg::t_group       o_grp,
    output b64u_pkg::t_q_stat      o_stat
);
    import b64u_pkg::*;

    localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int unsigned CntW = $clog2(QDepth + 1);

    t_group            r_mem [QDepth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_cnt == CntW'(QDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_grp        = r_mem[r_rd_ptr];

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        if (p == PtrW'(QDepth - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/b64u_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64u_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire b64u_pkg::t_group  i_grp,
    input  wire b64u_pkg::t_q_stat i_q_stat,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [b64u_pkg::SymW-1:0] o_m_tdata,
    output logic                   o_m_tuser,
    output logic                   o_m_tlast
);
    import b64u_pkg::*;

    logic [23:0]     r_bits;
    logic [1:0]      r_left;
    logic            r_final;
    logic            r_active;
    logic [23:0]     n_bits;
    logic [1:0]      n_left;
    logic            n_final;
    logic            n_active;
    logic            r_oval;
    logic [SymW-1:0] r_sym;
    logic            r_run_end;
    logic            r_msg_end;
    logic            out_free;
    logic            step;
    logic            done;

    assign out_free = !r_oval || i_m_tready;
    assign step     = r_active && out_free;
    assign done     = step && (r_left == 2'd0);
    // next group is taken as the current one hands over its last character
    assign o_pop    = !i_q_stat.empty && (!r_active || done);

    always_comb begin
        n_bits   = r_bits;
        n_left   = r_left;
        n_final  = r_final;
        n_active = r_active;
        if (o_pop) begin
            n_bits   = i_grp.bits;
            n_left   = i_grp.last_idx;
            n_final  = i_grp.final_grp;
            n_active = 1'b1;
        end else if (done) begin
            n_active = 1'b0;
        end else if (step) begin
            n_bits = {r_bits[17:0], 6'd0};
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_oval   <= 1'b0;
        end else begin
            r_active <= n_active;
            if (out_free) begin
                r_oval <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits  <= n_bits;
        r_left  <= n_left;
        r_final <= n_final;
        if (step) begin
            r_sym     <= sextet_char(r_bits[23:18]);
            r_run_end <= (r_left == 2'd0);
            r_msg_end <= (r_left == 2'd0) && r_final;
        end
    end

    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = r_sym;
    assign o_m_tuser  = r_run_end;
    assign o_m_tlast  = r_msg_end;

endmodule
`default_nettype wire

// ===== src/base64url_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming base64url encoder, no padding.
// Input stream: one message byte per transfer on i_s_tdata, i_s_tlast marks
// the final byte of the message. Output stream: one ASCII character per
// transfer on o_m_tdata; o_m_tuser flags the last character caused by one
// input byte, o_m_tlast flags the final character of the encoded message.
// Every third byte, and the final byte, produces a group of 2 to 4 characters.
// The front holds up to two pending bytes and pushes finished groups into a
// two-entry queue; the back serializes one character per cycle into the
// output register while that register is free.
// With the back idle, a completed group is registered in the queue, then in
// the back's group register, and then its first character in the output.
// Throughput: one byte per cycle while the queue has room, one character per
// cycle out while the receiver is ready; sustained input is limited by the
// single-character output channel, four characters per three bytes.
// Reset (synchronous, active low) drops pending bytes, queued groups and any
// character held in the output register.
// When the receiver stalls, the output holds its character, the back stops,
// the queue fills and o_s_tready falls once both entries are taken.
module base64url_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,   // last_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] symbol
    output logic            o_m_tuser,   // [0] run_end
    output logic            o_m_tlast    // message_end
);
    import b64u_pkg::*;

    t_q_stat q_stat;
    t_group  push_grp;
    t_group  head_grp;
    logic    push;
    logic    pop;

    b64u_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_grp      (push_grp)
    );

    b64u_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (push_grp),
        .i_pop   (pop),
        .o_grp   (head_grp),
        .o_stat  (q_stat)
    );

    b64u_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grp      (head_grp),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

// ===== dv/base64url_encoder_test.sv =====
`timescale 1ns / 1ps

module base64url_encoder_test;

    typedef struct packed {
        logic [7:0] symbol;
        logic       run_end;
        logic       message_end;
    } t_enc_char;

    // chars holds up to four characters, first one in the highest used byte
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic [2:0]  nchars;
        logic [31:0] chars;
    } t_byte_row;

    localparam logic [8*64-1:0] URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    // nchars == 0: result comes from the encoder model only
    localparam int DIRECTED_N = 25;
    localparam t_byte_row DIRECTED [DIRECTED_N] = '{
        '{8'h00, 1'b1, 3'd2, "AA"},      // single-byte message, all zeros
        '{8'hff, 1'b1, 3'd2, "_w"},      // single-byte message, all ones
        '{8'hff, 1'b0, 3'd0, 32'h0},
        '{8'hff, 1'b1, 3'd3, "__8"},
        '{8'h00, 1'b0, 3'd0, 32'h0},
        '{8'h00, 1'b1, 3'd3, "AAA"},
        '{8'hff, 1'b0, 3'd0, 32'h0},
        '{8'hff, 1'b0, 3'd0, 32'h0},
        '{8'hff, 1'b1, 3'd4, "____"},    // full group on the final byte
        '{8'h00, 1'b0, 3'd0, 32'h0},
        '{8'h00, 1'b0, 3'd0, 32'h0},
        '{8'h00, 1'b0, 3'd4, "AAAA"},    // full group, message continues
        '{8'hfb, 1'b1, 3'd2, "-w"},
        '{8'h4d, 1'b0, 3'd0, 32'h0},
        '{8'h61, 1'b0, 3'd0, 32'h0},
        '{8'h6e, 1'b1, 3'd4, "TWFu"},
        '{8'hfb, 1'b0, 3'd0, 32'h0},
        '{8'hef, 1'b0, 3'd0, 32'h0},
        '{8'hbe, 1'b0, 3'd4, "----"},
        '{8'h01, 1'b1, 3'd2, "AQ"},
        '{8'h4d, 1'b0, 3'd0, 32'h0},
        '{8'h61, 1'b1, 3'd3, "TWE"},
        '{8'h5a, 1'b0, 3'd0, 32'h0},
        '{8'ha5, 1'b0, 3'd0, 32'h0},
        '{8'h3c, 1'b1, 3'd0, 32'h0}
    };

    localparam int RANDOM_ITEMS = 85;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;  // [7:0] data_byte
    logic       i_s_tlast  = 1'b0;   // last_byte
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;           // [7:0] symbol
    logic       o_m_tuser;           // [0] run_end
    logic       o_m_tlast;           // message_end

    base64url_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    // encoder model state
    logic [15:0] held_bytes = 16'h0;
    logic [1:0]  held_count = 2'd0;

    t_enc_char   char_fifo[$];   // characters still owed by the block
    t_byte_row   sent_rows[$];   // rows driven but not yet transferred
    int          fail_count = 0;
    int          stall_left = 0;
    int unsigned ready_cyc  = 0;

    function automatic logic [7:0] url_char(input logic [5:0] idx);
        return URL_ALPHABET[8*(63 - int'(idx)) +: 8];
    endfunction

    // Returns the number of characters caused by one byte.
    function automatic int encode_byte(input logic [7:0] b, input logic fin,
                                       output t_enc_char grp [4]);
        logic [23:0] bits;
        logic        msg_done;
        int          n;
        if (held_count == 2'd0 && !fin) begin
            held_bytes = {b, 8'h00};
            held_count = 2'd1;
            return 0;
        end
        if (held_count == 2'd1 && !fin) begin
            held_bytes[7:0] = b;
            held_count = 2'd2;
            return 0;
        end
        if (held_count == 2'd0) begin
            bits = {b, 16'h0};
            n = 2;
            msg_done = 1'b1;
        end else if (held_count == 2'd1) begin
            bits = {held_bytes[15:8], b, 8'h00};
            n = 3;
            msg_done = 1'b1;
        end else begin
            bits = {held_bytes, b};
            n = 4;
            msg_done = fin;
        end
        for (int k = 0; k < n; k++) begin
            grp[k].symbol      = url_char(bits[23 - 6*k -: 6]);
            grp[k].run_end     = (k == n - 1);
            grp[k].message_end = (k == n - 1) && msg_done;
        end
        held_bytes = 16'h0;
        held_count = 2'd0;
        return n;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic take_byte();
        t_enc_char grp [4];
        t_byte_row row;
        int        n;
        row = '0;
        if (sent_rows.size() != 0) row = sent_rows.pop_front();
        n = encode_byte(i_s_tdata, i_s_tlast, grp);
        if (row.nchars != 0) begin
            n = row.nchars;
            for (int k = 0; k < n; k++) begin
                grp[k].symbol      = row.chars[8*(n - 1 - k) +: 8];
                grp[k].run_end     = (k == n - 1);
                grp[k].message_end = (k == n - 1) && i_s_tlast;
            end
        end
        for (int k = 0; k < n; k++) char_fifo.insert(char_fifo.size(), grp[k]);
    endtask

    task automatic check_char();
        t_enc_char want;
        t_enc_char got;
        got = '{o_m_tdata, o_m_tuser, o_m_tlast};
        if (char_fifo.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected char %h run_end %b message_end %b",
                         $realtime, got.symbol, got.run_end, got.message_end);
        end else begin
            want = char_fifo.pop_front();
            if (got != want) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: char exp %h/%b/%b got %h/%b/%b", $realtime,
                             want.symbol, want.run_end, want.message_end,
                             got.symbol, got.run_end, got.message_end);
            end
        end
    endtask

    // outputs first: a byte's characters never leave in its own transfer cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) check_char();
            if (i_s_tvalid && o_s_tready) take_byte();
        end
    end

    // receiver backpressure; one window in three of the cycle count starts no new stalls
    always @(posedge i_clk) begin
        ready_cyc++;
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if ((ready_cyc / 300) % 3 != 0) stall_left = pick_gap();
        end
    end

    task automatic send_byte(input t_byte_row row, input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= row.data;
        i_s_tlast  <= row.fin;
        sent_rows.insert(sent_rows.size(), row);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sent_rows.size() != 0 || char_fifo.size() != 0);
    endtask

    initial begin
        t_byte_row row;
        int        len;
        int        sent;
        logic      burst;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_N; i++) send_byte(DIRECTED[i], pick_gap());
        wait_drained();

        while (sent < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 9)
                                                : $urandom_range(10, 30);
            if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
            burst = ($urandom_range(0, 99) < 30);
            for (int i = 0; i < len; i++) begin
                row = '0;
                row.data = 8'($urandom_range(0, 255));
                row.fin  = (i == len - 1);
                send_byte(row, burst ? 0 : pick_gap());
                sent++;
            end
            if ($urandom_range(0, 99) < 15) wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (char_fifo.size() != 0) begin
            $display("%0d characters never arrived", char_fifo.size());
            fail_count += char_fifo.size();
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
src/b64u_pkg.sv
src/b64u_front.sv
src/b64u_fifo.sv
src/b64u_back.sv
src/base64url_encoder.sv
dv/base64url_encoder_test.sv
